[hdl/positional_list_engine_unit_assert.svh]
// assertion macros used by the list engine rtl
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("list engine check failed");

// next-cycle implication, checked outside reset
`define PLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("list engine check failed");

`endif

[hdl/ple_pkg.sv]
package ple_pkg;

   localparam int DEPTH_DEF = 16;

   localparam int OPCODE_W = 2;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic ins;
      logic del;
      logic rd;
   } cell_cmd_type;

endpackage

[hdl/ple_req_if.sv]
interface ple_req_if;
   import ple_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic [POS_W-1:0]           position;
   logic signed [DATA_W-1:0]   item_value;

   modport source (output valid, output opcode, output position, output item_value,
                   input ready);
   modport sink (input valid, input opcode, input position, input item_value,
                 output ready);
endinterface

[hdl/ple_rsp_if.sv]
interface ple_rsp_if;
   import ple_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   read_value;
   logic [STATUS_W-1:0]        status;
   logic [COUNT_W-1:0]         count;

   modport source (output valid, output read_value, output status, output count,
                   input ready);
   modport sink (input valid, input read_value, input status, input count,
                 output ready);
endinterface

[hdl/ple_cell.sv]
module ple_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic                               clock,
   input  ple_pkg::cell_cmd_type              cmd,
   input  logic [IDX_W-1:0]                   pos,
   input  logic signed [ple_pkg::DATA_W-1:0]  item_value,
   input  logic signed [ple_pkg::DATA_W-1:0]  from_left,
   input  logic signed [ple_pkg::DATA_W-1:0]  from_right,
   output logic signed [ple_pkg::DATA_W-1:0]  entry,
   output logic signed [ple_pkg::DATA_W-1:0]  rd_word
);
   import ple_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (MY_IDX == pos) begin
            entry_in = item_value;
         end else if (MY_IDX > pos) begin
            entry_in = from_left;
         end
      end else if (cmd.del) begin
         // everything from the hole upward slides down one place
         if (MY_IDX >= pos) begin
            entry_in = from_right;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry   = entry_ff;
   assign rd_word = (cmd.rd && (MY_IDX == pos)) ? entry_ff : '0;

endmodule

[hdl/ple_ctrl.sv]
module ple_ctrl #(
   parameter int DEPTH = ple_pkg::DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic [ple_pkg::OPCODE_W-1:0]      opcode,
   input  logic [ple_pkg::POS_W-1:0]         position,
   output ple_pkg::cell_cmd_type             cmd,
   output logic [IDX_W-1:0]                  pos_idx,
   output logic [ple_pkg::STATUS_W-1:0]      status,
   output logic [CNT_W-1:0]                  count_next,
   output logic [CNT_W-1:0]                  count_cur
);
   import ple_pkg::*;

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;

   assign pos_ext = CMP_W'(position);
   assign cnt_ext = CMP_W'(count_ff);
   // only used when in range, so the dropped high bits are zero then
   assign pos_idx = pos_ext[IDX_W-1:0];

   always_comb begin
      cmd      = '0;
      status   = ST_OK;
      count_in = count_ff;
      unique case (opcode)
         OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status = ST_RANGE;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               status = ST_FULL;
            end else begin
               cmd.ins  = fire;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               cmd.del  = fire;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               cmd.rd = fire;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   assign count_next = count_in;
   assign count_cur  = count_ff;

endmodule

[hdl/positional_list_engine_unit.sv]
// channel | dir | ports                                   | word
// req     | in  | valid ready opcode position item_value  | one list operation
// rsp     | out | valid ready read_value status count     | one result per operation
//
// one operation is accepted per cycle; its result shows in the output
// register the cycle after and the chain of cells shifts in the same edge.
// req.ready drops only while a result waits in the output register and
// rsp.ready is low. reset clears the count and the output valid; the
// cells hold no reset and are only read below the count.
module positional_list_engine_unit #(
   parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ple_req_if.sink    req,
   ple_rsp_if.source  rsp
);
   import ple_pkg::*;

   `include "positional_list_engine_unit_assert.svh"

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cell_cmd_type             cmd;
   logic [IDX_W-1:0]         pos_idx;
   logic [STATUS_W-1:0]      status;
   logic [CNT_W-1:0]         count_next;
   logic [CNT_W-1:0]         count_cur;
   logic                     fire;

   logic signed [DATA_W-1:0] entry_w [DEPTH];
   logic signed [DATA_W-1:0] rd_w    [DEPTH];
   logic signed [DATA_W-1:0] rd_merge;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] read_value_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;

   ple_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .opcode     (req.opcode),
      .position   (req.position),
      .cmd        (cmd),
      .pos_idx    (pos_idx),
      .status     (status),
      .count_next (count_next),
      .count_cur  (count_cur)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_w;
      logic signed [DATA_W-1:0] right_w;

      if (g == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = entry_w[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign right_w = entry_w[g];
      end else begin : g_mid_r
         assign right_w = entry_w[g+1];
      end

      ple_cell #(
         .INDEX (g),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (pos_idx),
         .item_value (req.item_value),
         .from_left  (left_w),
         .from_right (right_w),
         .entry      (entry_w[g]),
         .rd_word    (rd_w[g])
      );
   end

   // at most one cell answers a read, the rest give zero
   always_comb begin
      rd_merge = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_merge = rd_merge | rd_w[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         read_value_ff <= rd_merge;
         status_ff     <= status;
         rsp_count_ff  <= COUNT_W'(count_next);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = read_value_ff;
   assign rsp.status     = status_ff;
   assign rsp.count      = rsp_count_ff;

   `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_cur <= CNT_W'(DEPTH))
   `PLE_ASSERT_NOW(a_full_at_depth, fire && status == ST_FULL, count_cur == CNT_W'(DEPTH))
   `PLE_ASSERT_NOW(a_fail_no_data, rsp.valid && rsp.status != ST_OK, rsp.read_value == '0)
   `PLE_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp.valid)
   `PLE_ASSERT_NOW(a_one_action, 1'b1, $onehot0({cmd.ins, cmd.del, cmd.rd}))

endmodule
